@@ hw/rtl/i2dt_pkg.sv @@
// ----------------------------------------------------------------------------
// i2dt_pkg
// shared types, constants and the shift-add-3 step for the integer to
// decimal text converter
// ----------------------------------------------------------------------------
package i2dt_pkg;

  // width of the signed input value
  localparam int VALUE_WIDTH = 32;

  // ascii codes
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;
  localparam int         RADIX      = 10;

  // binary to bcd conversion: magnitude bits consumed per cycle
  localparam int BITS_PER_CYCLE = 4;
  localparam int CONV_STEPS     = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int PAD_WIDTH      = CONV_STEPS * BITS_PER_CYCLE;
  localparam int CNT_W          = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;

  // decimal digits of the largest magnitude, 2**(VALUE_WIDTH-1)
  localparam int DIGITS    = (VALUE_WIDTH * 3) / RADIX + 1;
  localparam int BCD_WIDTH = DIGITS * 4;
  localparam int DIDX_W    = $clog2(DIGITS);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // one classified item
  typedef struct packed {
    logic                   negative;
    logic [VALUE_WIDTH-1:0] mag;
  } item_t;

  // one shift-add-3 step: correct every digit, then shift in one bit
  function automatic logic [BCD_WIDTH-1:0] dabble_step(
    input logic [BCD_WIDTH-1:0] bcd,
    input logic                 bit_in
  );
    logic [BCD_WIDTH-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DIGITS; d++) begin
      if (adj[d*4 +: 4] >= 4'd5) begin
        adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
      end
    end
    return {adj[BCD_WIDTH-2:0], bit_in};
  endfunction

endpackage

@@ hw/rtl/i2dt_front.sv @@
// ----------------------------------------------------------------------------
// i2dt_front
// accepts a value, splits it into sign and unsigned magnitude, and holds it
// until the queue takes it
// ----------------------------------------------------------------------------
module i2dt_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [i2dt_pkg::VALUE_WIDTH-1:0]  in_value,
  output logic                              push,
  output i2dt_pkg::item_t                   push_item,
  input  logic                              q_full
);
  import i2dt_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  // stage can take a new value when empty or draining into the queue
  assign busy   = valid_r && q_full;
  assign accept = start && !busy;
  assign push   = valid_r && !q_full;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (push) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt         = 1'b1;
      item_nxt.negative = in_value[VALUE_WIDTH-1];
      // the most negative value negates to itself, correct as unsigned
      item_nxt.mag      = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign push_item = item_r;

endmodule

@@ hw/rtl/i2dt_queue.sv @@
// ----------------------------------------------------------------------------
// i2dt_queue
// short register fifo between the front and the back
// ----------------------------------------------------------------------------
module i2dt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2dt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output i2dt_pkg::item_t q_item
);
  import i2dt_pkg::*;

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/i2dt_back.sv @@
// ----------------------------------------------------------------------------
// i2dt_back
// converts a magnitude to bcd by shift-add-3, finds the leading digit and
// emits the sign and digits one per cycle
// ----------------------------------------------------------------------------
module i2dt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  i2dt_pkg::item_t q_item,
  output logic            pop,
  output logic            out_valid,
  output logic [6:0]      out_char_code,
  output logic            out_is_last
);
  import i2dt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_FIND = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [PAD_WIDTH-1:0] shift_r, shift_nxt;
  logic [BCD_WIDTH-1:0] bcd_r, bcd_nxt;
  logic                 neg_r, neg_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIDX_W-1:0]    idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [6:0]           char_r, char_nxt;
  logic                 last_r, last_nxt;

  logic [BCD_WIDTH-1:0] bcd_v;
  logic [PAD_WIDTH-1:0] sh_v;
  logic [DIDX_W-1:0]    lead;
  logic [3:0]           digit;

  // highest nonzero digit, zero for a zero value
  always_comb begin
    lead = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        lead = DIDX_W'(d);
      end
    end
  end

  assign digit = bcd_r[idx_r*4 +: 4];

  always_comb begin
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    char_nxt      = char_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    bcd_v         = bcd_r;
    sh_v          = shift_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          shift_nxt = PAD_WIDTH'(q_item.mag);
          bcd_nxt   = '0;
          neg_nxt   = q_item.negative;
          cnt_nxt   = CNT_W'(CONV_STEPS - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        for (int b = 0; b < BITS_PER_CYCLE; b++) begin
          bcd_v = dabble_step(bcd_v, sh_v[PAD_WIDTH-1]);
          sh_v  = {sh_v[PAD_WIDTH-2:0], 1'b0};
        end
        bcd_nxt   = bcd_v;
        shift_nxt = sh_v;
        if (cnt_r == '0) begin
          state_nxt = ST_FIND;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIND: begin
        idx_nxt   = lead;
        state_nxt = neg_r ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        char_nxt      = CHAR_MINUS;
        last_nxt      = 1'b0;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        char_nxt      = CHAR_ZERO + {3'b000, digit};
        last_nxt      = (idx_r == '0);
        if (idx_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_is_last   = last_r;

endmodule

@@ hw/rtl/integer_to_decimal_text_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_decimal_text_top
// signed two's-complement integer to decimal ascii text, one character per
// output transaction, most significant first
// ----------------------------------------------------------------------------
//
// channel  direction  handshake            payload
// -------  ---------  -------------------  ---------------------------------
// input    in         start high, busy low  in_value (VALUE_WIDTH, signed)
// result   out        out_valid strobe      out_char_code (7), out_is_last (1)
//
// - once the back end picks a number up, it converts it by shift-add-3
//   (BITS_PER_CYCLE magnitude bits a cycle), then emits one character per
//   cycle; it takes the next number only after the last character is out
// - the front stage and a two-entry queue take up to three further numbers
//   while the back end works; busy rises when both are full
// - rst_n is synchronous and active low; it empties the queue and idles the
//   back end
// - characters of one number leave on consecutive cycles; the receiver
//   cannot stall them
//
module integer_to_decimal_text_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [i2dt_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                             out_valid,
  output logic [6:0]                       out_char_code,
  output logic                             out_is_last
);
  import i2dt_pkg::*;

  // front to queue
  logic  push;
  item_t push_item;
  logic  q_full;

  // queue to back
  logic  q_valid;
  item_t q_item;
  logic  pop;

  // accept and classify: sign bit plus unsigned magnitude
  i2dt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_value  (in_value),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // decouples acceptance from conversion
  i2dt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // bcd conversion and character emission
  i2dt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

endmodule

@@ hw/rtl/i2dt_checker.sv @@
// ----------------------------------------------------------------------------
// i2dt_checker
// port-level checks on the character stream of the converter
// ----------------------------------------------------------------------------
module i2dt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [6:0] out_char_code,
  input logic       out_is_last
);
  import i2dt_pkg::*;

  // every character is a minus sign or a decimal digit
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CHAR_MINUS) ||
                  ((out_char_code >= CHAR_ZERO) && (out_char_code <= CHAR_ZERO + 7'd9)))
    else $error("illegal character code");

  // a minus sign never ends a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_char_code == CHAR_MINUS)) |-> !out_is_last)
    else $error("minus sign flagged last");

  // characters of one number come back to back
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_last) |=> out_valid)
    else $error("gap inside a number's text");

  // a minus sign is followed by a digit, never another minus
  a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_char_code == CHAR_MINUS)) |=> (out_char_code != CHAR_MINUS))
    else $error("minus sign repeated");

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output strobe right after reset");

endmodule

bind integer_to_decimal_text_top i2dt_checker u_i2dt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_char_code (out_char_code),
  .out_is_last   (out_is_last)
);

@@ tb/i2dt_checker.sv @@
// ----------------------------------------------------------------------------
// i2dt_tb_checker
// watches the number and character channels of the integer to decimal text
// converter, spells each accepted number and compares every character
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2dt_tb_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic [i2dt_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic                             out_valid,
  input  logic [6:0]                       out_char_code,
  input  logic                             out_is_last,
  output int                               mismatch_count,
  output int                               chars_pending
);
  import i2dt_pkg::*;

  typedef struct {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  text_char_t text_chars[$];

  // expected text of one number, most significant character first
  function automatic void spell_decimal(input logic [VALUE_WIDTH-1:0] value);
    logic [VALUE_WIDTH-1:0] mag;
    logic [6:0]             digit_chars[$];
    logic                   negative;
    negative = value[VALUE_WIDTH-1];
    mag = negative ? (~value + 1'b1) : value;
    do begin
      digit_chars.push_front(CHAR_ZERO + 7'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (negative) text_chars.push_back('{CHAR_MINUS, 1'b0});
    foreach (digit_chars[i])
      text_chars.push_back('{digit_chars[i], (i == digit_chars.size() - 1)});
  endfunction

  always @(posedge clk) begin
    text_char_t exp_char;
    if (!rst_n) begin
      mismatch_count = 0;
      chars_pending  = 0;
      text_chars.delete();
    end else begin
      // characters first: one leaving now never belongs to a number taken now
      if (out_valid === 1'b1) begin
        if (text_chars.size() == 0) begin
          $display("%0t: unexpected character, actual char_code %0d is_last %0b",
                   $time, out_char_code, out_is_last);
          mismatch_count++;
        end else begin
          exp_char = text_chars.pop_front();
          if (out_char_code !== exp_char.code) begin
            $display("%0t: char_code expected %0d actual %0d",
                     $time, exp_char.code, out_char_code);
            mismatch_count++;
          end
          if (out_is_last !== exp_char.last) begin
            $display("%0t: is_last expected %0b actual %0b",
                     $time, exp_char.last, out_is_last);
            mismatch_count++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) spell_decimal(in_value);
      chars_pending = text_chars.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives directed then random signed numbers in bursts into the integer to
// decimal text converter; a checker predicts and compares every character
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import i2dt_pkg::*;

  localparam int RANDOM_ITEMS = 310;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [VALUE_WIDTH-1:0] in_value;
  logic                   out_valid;
  logic [6:0]             out_char_code;
  logic                   out_is_last;
  int                     mismatch_count;
  int                     chars_pending;

  // 2 ns clock period
  always #1 clk = ~clk;

  integer_to_decimal_text_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

  i2dt_tb_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_char_code  (out_char_code),
    .out_is_last    (out_is_last),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  // present one number at the falling edge and hold it until a rising edge
  // finds busy low; start stays high so a following call keeps the burst going
  task automatic send_number(input logic [VALUE_WIDTH-1:0] value);
    @(negedge clk);
    start    <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // drop start and leave the input idle for a number of cycles (at least one)
  task automatic idle_input(input int cycles);
    @(negedge clk);
    start    <= 1'b0;
    in_value <= $urandom();
    repeat (cycles - 1) @(negedge clk);
  endtask

  // random number: mostly a chosen digit count so every text length shows up,
  // the rest raw 32-bit patterns so every input bit toggles
  function automatic logic [VALUE_WIDTH-1:0] random_number();
    longint lo;
    longint hi;
    longint pick;
    int     digits;
    if ($urandom_range(0, 3) == 0) return $urandom();
    digits = $urandom_range(1, 10);
    lo = 1;
    repeat (digits - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (digits == 1) lo = 0;
    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
    pick = lo + longint'($urandom_range(0, 32'(hi - lo)));
    // the negative side reaches one further, down to the most negative value
    if ($urandom_range(0, 1) == 1) begin
      if (pick == 64'sd2147483647 && $urandom_range(0, 1) == 1) pick = pick + 1;
      pick = -pick;
    end
    return VALUE_WIDTH'(pick);
  endfunction

  // edge cases: zero, unit values, digit count borders, both extremes,
  // the most negative value and alternating bit patterns
  logic [VALUE_WIDTH-1:0] directed_numbers[] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
    32'sd100, -32'sd999, 32'sd12345, 32'sd999999999, -32'sd999999999,
    32'sd1000000000, -32'sd1000000000, 32'sd2147483647, -32'sd2147483647,
    32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000
  };

  initial begin
    int sent;
    int burst_len;
    bit drained_mid;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    drained_mid = 1'b0;
    // hold the synchronous reset low, then release it
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed numbers back to back, then let everything drain
    foreach (directed_numbers[i]) send_number(directed_numbers[i]);
    idle_input(1);
    wait (chars_pending == 0);

    // random bursts; gaps land anywhere in the conversion and character phases
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 14);
      for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
        send_number(random_number());
        sent++;
      end
      case ($urandom_range(0, 3))
        0: idle_input($urandom_range(15, 40));
        default: idle_input($urandom_range(1, 6));
      endcase
      // halfway through, hold off until every character has come out
      if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
        wait (chars_pending == 0);
        drained_mid = 1'b1;
      end
    end

    // drain, then allow the latency of one more number for stray characters
    wait (chars_pending == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/i2dt_pkg.sv
hw/rtl/i2dt_front.sv
hw/rtl/i2dt_queue.sv
hw/rtl/i2dt_back.sv
hw/rtl/integer_to_decimal_text_top.sv
hw/rtl/i2dt_checker.sv
tb/i2dt_checker.sv
tb/testbench.sv
